/* rtl/tgarle_pkg.sv */
// tgarle_pkg: shared types and codes for the targa run-length pixel decoder
// used by tgarle_pixel_fmt and tga_rle_pixel_decoder; no dependencies

package tgarle_pkg;

  // configuration register indexes
  localparam logic [1:0] RegBytesPerPixel = 2'd0;
  localparam logic [1:0] RegRunLengthMode = 2'd1;
  localparam logic [1:0] RegImageWidth    = 2'd2;
  localparam logic [1:0] RegImageHeight   = 2'd3;

  // source pixel size codes
  localparam logic [2:0] Bpp16 = 3'd2;
  localparam logic [2:0] Bpp24 = 3'd3;
  localparam logic [2:0] Bpp32 = 3'd4;

  localparam int unsigned DimW   = 15;
  localparam int unsigned TotalW = 2 * DimW;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  // bytes taken by one source pixel; unused codes take one byte
  function automatic logic [2:0] pixel_size(input logic [2:0] bpp);
    logic [2:0] size;
    case (bpp)
      Bpp16:   size = 3'd2;
      Bpp24:   size = 3'd3;
      Bpp32:   size = 3'd4;
      default: size = 3'd1;
    endcase
    return size;
  endfunction

endpackage

/* rtl/tgarle_pixel_fmt.sv */
// tgarle_pixel_fmt: turns the gathered bytes of one source pixel into rgba
// depends on tgarle_pkg

module tgarle_pixel_fmt (
  input  logic [2:0]        bpp_i,
  input  logic [23:0]       held_i,
  input  logic [7:0]        last_byte_i,
  output tgarle_pkg::rgba_t rgba_o
);

  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;

  assign b0 = held_i[7:0];
  assign b1 = held_i[15:8];
  assign b2 = held_i[23:16];

  // the last byte of the pixel arrives live, earlier ones come from the holding register
  always_comb begin
    case (bpp_i)
      tgarle_pkg::Bpp32: begin
        rgba_o.red   = b2;
        rgba_o.green = b1;
        rgba_o.blue  = b0;
        rgba_o.alpha = last_byte_i;
      end
      tgarle_pkg::Bpp24: begin
        rgba_o.red   = last_byte_i;
        rgba_o.green = b1;
        rgba_o.blue  = b0;
        rgba_o.alpha = 8'hff;
      end
      tgarle_pkg::Bpp16: begin
        // 5-5-5 expansion, top bit of the high byte is the alpha bit
        rgba_o.red   = {last_byte_i[6:2], 3'b000};
        rgba_o.green = {last_byte_i[1:0], b0[7:5], 3'b000};
        rgba_o.blue  = {b0[4:0], 3'b000};
        rgba_o.alpha = {last_byte_i[7], 7'b0000000};
      end
      default: begin
        rgba_o.red   = 8'h00;
        rgba_o.green = 8'h00;
        rgba_o.blue  = 8'h00;
        rgba_o.alpha = 8'hff;
      end
    endcase
  end

endmodule

/* rtl/tga_rle_pixel_decoder.sv */
// tga_rle_pixel_decoder: targa pixel-data byte stream to rgba pixel runs
// depends on tgarle_pkg and tgarle_pixel_fmt
//
// Usage:
//   s_axis carries one pixel-data byte per request (tdata[7:0]).
//   m_axis carries one decoded colour per request; tlast marks the request
//   that completes the image's last pixel.
//   cfg_we_i / cfg_idx_i / cfg_data_i write bytes_per_pixel (0),
//   run_length_mode (1), image_width (2), image_height (3); write only while
//   the block is idle, a byte may follow in the next cycle.
// Latency and throughput:
//   one byte per cycle unless m_axis stalls; a pixel's last byte appears on
//   m_axis in the cycle after it is taken. Other bytes (packet headers,
//   leading pixel bytes) only update the packet and pixel counters.
//   The image size product is kept in a register behind the config port.
// Reset: all counters clear; the next byte starts a new image.
// Stall: the output register holds its request; s_axis_tready stays high
//   while the output register is empty or being drained this cycle.

module tga_rle_pixel_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  // pixel output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // red, green, blue, alpha, repeat_count
  output logic        m_axis_tlast    // image_end
);

  localparam int unsigned DimW   = tgarle_pkg::DimW;
  localparam int unsigned TotalW = tgarle_pkg::TotalW;

  // configuration registers
  logic [2:0]        bpp_q;
  logic              rle_q;
  logic [DimW-1:0]   width_q,  width_d;
  logic [DimW-1:0]   height_q, height_d;
  logic [TotalW-1:0] total_q;

  // image and packet state
  logic              awh_q,  awh_d;
  logic              run_q,  run_d;
  logic [7:0]        pkt_q,  pkt_d;
  logic [1:0]        pos_q,  pos_d;
  logic [23:0]       held_q, held_d;
  logic [TotalW-1:0] left_q, left_d;

  // output register
  logic              m_valid_q;
  logic [39:0]       m_data_q;
  logic              m_last_q;

  logic              in_acc;
  logic              res_valid;
  logic              res_last;
  logic [7:0]        res_rep;
  logic [2:0]        size;
  logic              pix_done;
  logic [23:0]       held_eff;
  logic [7:0]        pkt_eff;
  logic              run_eff;
  logic              awh_eff;
  logic [1:0]        pos_eff;
  logic [TotalW-1:0] left_eff;
  logic [TotalW-1:0] left_after;
  logic [7:0]        rep_run;
  tgarle_pkg::rgba_t rgba;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign size          = tgarle_pkg::pixel_size(bpp_q);

  // next image size, so the product follows a write in the same cycle
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tgarle_pkg::RegImageWidth:  width_d  = cfg_data_i[DimW-1:0];
        tgarle_pkg::RegImageHeight: height_d = cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  // config writes, image size product kept registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= 3'd3;
      rle_q    <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      total_q  <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      total_q  <= width_d * height_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tgarle_pkg::RegBytesPerPixel: bpp_q <= cfg_data_i[2:0];
          tgarle_pkg::RegRunLengthMode: rle_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // image start clears the state and loads the pixel total
  always_comb begin
    if (left_q == '0) begin
      awh_eff  = 1'b1;
      run_eff  = 1'b0;
      pkt_eff  = '0;
      pos_eff  = '0;
      held_eff = '0;
      left_eff = total_q;
    end else begin
      awh_eff  = awh_q;
      run_eff  = run_q;
      pkt_eff  = pkt_q;
      pos_eff  = pos_q;
      held_eff = held_q;
      left_eff = left_q;
    end
  end

  tgarle_pixel_fmt u_fmt (
    .bpp_i       (bpp_q),
    .held_i      (held_eff),
    .last_byte_i (s_axis_tdata),
    .rgba_o      (rgba)
  );

  assign pix_done = ({1'b0, pos_eff} + 3'd1) >= size;

  // run length clipped to what is left of the image
  always_comb begin
    rep_run = (pkt_eff == '0) ? 8'd1 : pkt_eff;
    if (TotalW'(rep_run) > left_eff) begin
      rep_run = left_eff[7:0];
    end
  end

  // per-byte state update
  always_comb begin
    awh_d      = awh_q;
    run_d      = run_q;
    pkt_d      = pkt_q;
    pos_d      = pos_q;
    held_d     = held_q;
    left_d     = left_q;
    res_valid  = 1'b0;
    res_rep    = 8'd1;
    res_last   = 1'b0;
    left_after = left_eff;
    if (in_acc && (left_eff != '0)) begin
      awh_d  = awh_eff;
      run_d  = run_eff;
      pkt_d  = pkt_eff;
      pos_d  = pos_eff;
      held_d = held_eff;
      left_d = left_eff;
      if (rle_q && awh_eff) begin
        // packet header
        run_d = s_axis_tdata[7];
        pkt_d = {1'b0, s_axis_tdata[6:0]} + 8'd1;
        awh_d = 1'b0;
      end else if (!pix_done) begin
        // gather a leading byte of the pixel
        case (pos_eff)
          2'd0:    held_d[7:0]   = s_axis_tdata;
          2'd1:    held_d[15:8]  = s_axis_tdata;
          2'd2:    held_d[23:16] = s_axis_tdata;
          default: ;
        endcase
        pos_d = pos_eff + 2'd1;
      end else begin
        // pixel complete
        res_valid = 1'b1;
        pos_d     = '0;
        held_d    = '0;
        if (rle_q && run_eff) begin
          res_rep = rep_run;
          pkt_d   = '0;
          awh_d   = 1'b1;
        end else if (rle_q) begin
          if (pkt_eff != '0) begin
            pkt_d = pkt_eff - 8'd1;
          end
          if ((pkt_eff == '0) || (pkt_eff == 8'd1)) begin
            awh_d = 1'b1;
          end
        end
        left_after = left_eff - TotalW'(res_rep);
        res_last   = (left_after == '0);
        left_d     = left_after;
        if (res_last) begin
          awh_d  = 1'b1;
          run_d  = 1'b0;
          pkt_d  = '0;
          pos_d  = '0;
          held_d = '0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awh_q  <= 1'b1;
      run_q  <= 1'b0;
      pkt_q  <= '0;
      pos_q  <= '0;
      held_q <= '0;
      left_q <= '0;
    end else begin
      awh_q  <= awh_d;
      run_q  <= run_d;
      pkt_q  <= pkt_d;
      pos_q  <= pos_d;
      held_q <= held_d;
      left_q <= left_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      m_valid_q <= res_valid;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && res_valid) begin
      m_data_q <= {res_rep, rgba.alpha, rgba.blue, rgba.green, rgba.red};
      m_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // no image in progress means all packet and pixel state is at rest
  a_idle_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q == '0) |-> (awh_q && !run_q && (pkt_q == '0) && (pos_q == '0)))
    else $error("state not cleared while no image is in progress");

  // the request that ends the image leaves the image counter empty
  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid && res_last) |=> (left_q == '0))
    else $error("image counter not empty after image end");

  // a delivered colour always covers at least one pixel
  a_rep_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:32] != 8'd0))
    else $error("zero repeat count on output");

  // repeats above one come only from run packets
  a_rep_rle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid && (res_rep != 8'd1)) |-> (rle_q && run_eff))
    else $error("repeat count above one outside a run packet");

endmodule

/* tb/tga_rle_checker.sv */
// tga_rle_checker: watches the byte and pixel channels of tga_rle_pixel_decoder,
// predicts every decoded pixel run and compares it with what the block sends
// depends on tgarle_pkg for register indexes, pixel size codes and rgba_t

module tga_rle_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // data_byte
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,   // red, green, blue, alpha, repeat_count
  input  logic        m_tlast_i,   // image_end
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tgarle_pkg::rgba_t colour;
    logic [7:0]        repeat_count;
    logic              image_end;
  } pixel_run_t;

  // shadow of the configuration registers
  logic [2:0]  cfg_bpp;
  logic        cfg_rle;
  logic [14:0] cfg_width;
  logic [14:0] cfg_height;

  // shadow of the decoder state
  logic        hdr_wait;
  logic        run_pkt;
  logic [7:0]  pkt_left;
  logic [1:0]  byte_pos;
  logic [23:0] held;
  logic [29:0] img_left;

  pixel_run_t runs_due[$];
  int mismatches = 0;

  assign fail_count_o = mismatches;

  // source bytes per pixel; spare codes take a single byte
  function automatic logic [2:0] bytes_in_pixel(input logic [2:0] code);
    if (code >= tgarle_pkg::Bpp16 && code <= tgarle_pkg::Bpp32) return code;
    return 3'd1;
  endfunction

  task automatic clear_image();
    hdr_wait = 1'b1;
    run_pkt  = 1'b0;
    pkt_left = '0;
    byte_pos = '0;
    held     = '0;
    img_left = '0;
  endtask

  // advance the shadow decoder by one byte, queue the run it completes
  task automatic decode_byte(input logic [7:0] data_byte);
    logic [2:0]  size;
    logic [29:0] total;
    logic [29:0] run_len;
    logic [7:0]  pb [0:3];
    pixel_run_t  run;
    size = bytes_in_pixel(cfg_bpp);
    // image start: load the pixel count, an empty image drops the byte
    if (img_left == '0) begin
      total = 30'(cfg_width) * 30'(cfg_height);
      if (total == '0) return;
      clear_image();
      img_left = total;
    end
    // packet header
    if (cfg_rle && hdr_wait) begin
      run_pkt  = data_byte[7];
      pkt_left = {1'b0, data_byte[6:0]} + 8'd1;
      hdr_wait = 1'b0;
      return;
    end
    // leading bytes of a pixel
    if ({1'b0, byte_pos} + 3'd1 < size) begin
      held     = held | (24'(data_byte) << (8 * byte_pos));
      byte_pos = byte_pos + 2'd1;
      return;
    end
    pb[0] = held[7:0];
    pb[1] = held[15:8];
    pb[2] = held[23:16];
    pb[3] = 8'h00;
    pb[size - 3'd1] = data_byte;
    byte_pos = '0;
    held     = '0;
    // colour decode
    case (cfg_bpp)
      tgarle_pkg::Bpp32: begin
        run.colour.red   = pb[2];
        run.colour.green = pb[1];
        run.colour.blue  = pb[0];
        run.colour.alpha = pb[3];
      end
      tgarle_pkg::Bpp24: begin
        run.colour.red   = pb[2];
        run.colour.green = pb[1];
        run.colour.blue  = pb[0];
        run.colour.alpha = 8'hFF;
      end
      tgarle_pkg::Bpp16: begin
        run.colour.red   = {pb[1][6:2], 3'b000};
        run.colour.green = {pb[1][1:0], pb[0][7:5], 3'b000};
        run.colour.blue  = {pb[0][4:0], 3'b000};
        run.colour.alpha = {pb[1][7], 7'b0};
      end
      default: begin
        run.colour.red   = 8'h00;
        run.colour.green = 8'h00;
        run.colour.blue  = 8'h00;
        run.colour.alpha = 8'hFF;
      end
    endcase
    // run length, clipped to what is left of the image
    if (cfg_rle && run_pkt) begin
      run_len = (pkt_left == '0) ? 30'd1 : 30'(pkt_left);
      if (run_len > img_left) run_len = img_left;
      pkt_left = '0;
      hdr_wait = 1'b1;
    end else begin
      run_len = 30'd1;
      if (cfg_rle) begin
        if (pkt_left != '0) pkt_left = pkt_left - 8'd1;
        if (pkt_left == '0) hdr_wait = 1'b1;
      end
    end
    img_left         = img_left - run_len;
    run.repeat_count = run_len[7:0];
    run.image_end    = (img_left == '0);
    if (img_left == '0) clear_image();
    runs_due.push_back(run);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare one output request with the oldest predicted run
  task automatic check_pixel();
    pixel_run_t want;
    if (runs_due.size() == 0) begin
      $display("%0t: unexpected pixel, expected none, actual tdata %h tlast %b",
               $time, m_tdata_i, m_tlast_i);
      mismatches++;
      return;
    end
    want = runs_due.pop_front();
    check_field("red", want.colour.red, m_tdata_i[7:0]);
    check_field("green", want.colour.green, m_tdata_i[15:8]);
    check_field("blue", want.colour.blue, m_tdata_i[23:16]);
    check_field("alpha", want.colour.alpha, m_tdata_i[31:24]);
    check_field("repeat_count", want.repeat_count, m_tdata_i[39:32]);
    check_field("image_end", 8'(want.image_end), 8'(m_tlast_i));
  endtask

  // output first: a byte taken now cannot show up in the same cycle;
  // a byte taken with a register write still sees the old setting
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_bpp    = tgarle_pkg::Bpp24;
      cfg_rle    = 1'b0;
      cfg_width  = '0;
      cfg_height = '0;
      clear_image();
      runs_due.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) check_pixel();
      if (s_tvalid_i && s_tready_i) decode_byte(s_tdata_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tgarle_pkg::RegBytesPerPixel: cfg_bpp    = cfg_data_i[2:0];
          tgarle_pkg::RegRunLengthMode: cfg_rle    = cfg_data_i[0];
          tgarle_pkg::RegImageWidth:    cfg_width  = cfg_data_i;
          tgarle_pkg::RegImageHeight:   cfg_height = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o <= runs_due.size();
  end

endmodule

/* tb/tb_top.sv */
// tb_top: byte stimulus, receiver back-pressure and verdict for tga_rle_pixel_decoder
// depends on tgarle_pkg, the block itself and tga_rle_checker

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NumPhases  = 9;
  localparam int          PhaseBytes = 210;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned WatchLimit = 3000;

  // pixel size codes the block treats as one opaque black byte
  localparam logic [2:0] BppSpareLow  = 3'd0;
  localparam logic [2:0] BppSpareHigh = 3'd7;
  localparam logic       RawMode      = 1'b0;
  localparam logic       PacketMode   = 1'b1;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        cfg_we   = 1'b0;
  logic [1:0]  cfg_idx  = '0;
  logic [14:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int          fail_count;
  int          pending;
  int unsigned src_idle    = 0;
  int unsigned snk_stall   = 0;
  int unsigned hold_reqs   = 0;
  int unsigned bytes_sent  = 0;
  int unsigned quiet_ticks = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tga_rle_pixel_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  tga_rle_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // watchdog: too long without any request moving on either side
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_ticks = 0;
    else quiet_ticks++;
    if (quiet_ticks >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin : receiver
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        hold_left   = LongHold;
      end
      if (hold_left != 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= snk_stall);
      end
    end
  end

  // offer one byte with random idle cycles in front; entered and left at negedge
  task automatic send_byte(input logic [7:0] data_byte);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = data_byte;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // nothing in flight and a few cycles of margin before a register write
  task automatic quiesce();
    wait_drain();
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [2:0] bpp, input logic rle,
                            input logic [14:0] width, input logic [14:0] height);
    write_reg(tgarle_pkg::RegBytesPerPixel, 15'(bpp));
    write_reg(tgarle_pkg::RegRunLengthMode, 15'(rle));
    write_reg(tgarle_pkg::RegImageWidth, width);
    write_reg(tgarle_pkg::RegImageHeight, height);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one raw pixel, or one packet with header and matching pixel bytes
  task automatic send_packet(input logic [2:0] bpp, input logic rle);
    int unsigned count;
    int unsigned n;
    logic [7:0]  hdr;
    n = int'(tgarle_pkg::pixel_size(bpp));
    if (rle == RawMode) begin
      repeat (n) send_byte(rand_byte());
      return;
    end
    count = ($urandom_range(15) == 0) ? $urandom_range(127) : $urandom_range(5);
    hdr   = {1'($urandom_range(1)), 7'(count)};
    send_byte(hdr);
    if (!hdr[7]) n = n * (count + 1);
    repeat (n) send_byte(rand_byte());
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    logic [2:0]  bpp;
    logic        rle;
    logic [14:0] width;
    logic [14:0] height;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset size is zero: bytes are dropped without a result
    send_byte(8'h00);
    send_byte(8'hFF);
    quiesce();

    // raw 24-bit: an all-zero pixel then an all-ones pixel ending the image
    set_config(tgarle_pkg::Bpp24, RawMode, 15'd2, 15'd1);
    repeat (3) send_byte(8'h00);
    repeat (3) send_byte(8'hFF);
    quiesce();

    // 16-bit packets: run of two, then a raw packet of one
    set_config(tgarle_pkg::Bpp16, PacketMode, 15'd3, 15'd1);
    send_byte(8'h81);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    quiesce();

    // run of 128 clipped to the four pixels of the image
    set_config(tgarle_pkg::Bpp32, PacketMode, 15'd2, 15'd2);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
    quiesce();

    // raw packet of six cut off by the image end after two pixels
    set_config(tgarle_pkg::Bpp16, PacketMode, 15'd2, 15'd1);
    send_byte(8'h05);
    send_byte(8'h1F);
    send_byte(8'h7C);
    send_byte(8'hE0);
    send_byte(8'h83);
    quiesce();

    // spare size codes: one byte per pixel, opaque black
    set_config(BppSpareLow, RawMode, 15'd3, 15'd1);
    send_byte(8'hA5);
    quiesce();
    write_reg(tgarle_pkg::RegBytesPerPixel, 15'(BppSpareHigh));
    send_byte(8'h5A);
    send_byte(8'h3C);
    quiesce();

    // pixel size shrinks mid-pixel: the next byte completes it
    set_config(tgarle_pkg::Bpp32, RawMode, 15'd1, 15'd1);
    send_byte(8'h11);
    send_byte(8'h22);
    quiesce();
    write_reg(tgarle_pkg::RegBytesPerPixel, 15'(tgarle_pkg::Bpp16));
    send_byte(8'h33);

    // random phases; register changes may land in the middle of an image
    for (int phase = 0; phase < NumPhases; phase++) begin
      quiesce();
      if (phase == 0) begin
        bpp = tgarle_pkg::Bpp24;
        rle = PacketMode;  width = 15'd5;     height = 15'd4;
      end else if (phase == NumPhases - 2) begin
        bpp = 3'($urandom_range(tgarle_pkg::Bpp16, tgarle_pkg::Bpp32));
        rle = PacketMode;  width = 15'd0;     height = 15'd32767;
      end else if (phase == NumPhases - 1) begin
        bpp = tgarle_pkg::Bpp32;
        rle = RawMode;     width = 15'd32767; height = 15'd32767;
      end else begin
        bpp    = ($urandom_range(7) == 0)
                 ? 3'($urandom_range(7))
                 : 3'($urandom_range(tgarle_pkg::Bpp16, tgarle_pkg::Bpp32));
        rle    = 1'($urandom_range(1));
        width  = 15'($urandom_range(1, 6));
        height = 15'($urandom_range(1, 6));
      end
      set_config(bpp, rle, width, height);
      case (phase % 4)
        0:       begin src_idle = 0;  snk_stall = 0;  end
        1:       begin src_idle = 78; snk_stall = 0;  end
        2:       begin src_idle = 0;  snk_stall = 78; end
        default: begin src_idle = 18; snk_stall = 18; end
      endcase
      // long receiver hold-off while bytes keep coming
      if (phase == 0) begin
        @(posedge clk_i);
        hold_reqs++;
        @(negedge clk_i);
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        if ($urandom_range(39) == 0) wait_drain();
        else if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) send_byte(rand_byte());
        else send_packet(bpp, rle);
      end
    end

    // drain and settle
    wait_drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
